/* rtl/utlm_pkg.sv */
// ----------------------------------------------------------------------------
// utlm_pkg: shared types and constants of the text layout measure unit
// glyph table entry, decoded character info, pen sequencer load and codes
// ----------------------------------------------------------------------------
package utlm_pkg;

  // glyph table geometry
  localparam int GLYPH_COUNT = 1024;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

  // tab expansion
  localparam int TAB_SPACES = 3;
  localparam int REP_W      = $clog2(TAB_SPACES + 1);

  // decoded code point width
  localparam int CODE_W = 21;

  localparam logic [CODE_W-1:0] TAB_CODE   = CODE_W'(9);
  localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);

  // utf-8 lead byte thresholds and payload masks
  localparam logic [7:0] LEAD4      = 8'hF0;
  localparam logic [7:0] LEAD3      = 8'hE0;
  localparam logic [7:0] LEAD2      = 8'hC0;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam int         CONT_BITS  = 6;
  localparam int         ADV_FRAC   = 6;

  // coordinates
  localparam int                 COORD_W = 24;
  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = 24'sh800000;
  localparam logic [15:0]        LINES_MAX = 16'hFFFF;

  localparam logic [9:0] LINE_PITCH_RST = 10'd16;

  // input item kinds
  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_GLYPH = 1'b1;

  // result kinds
  localparam logic RES_BOX = 1'b0;
  localparam logic RES_SUM = 1'b1;

  // one glyph table entry: shape and step together
  typedef struct packed {
    logic [11:0] bx;
    logic [11:0] by;
    logic [11:0] w;
    logic [11:0] h;
    logic [17:0] adv;
    logic        rend;
  } glyph_t;

  // what the decoder says about the byte just taken
  typedef struct packed {
    logic done;
    logic want;
    logic last;
    logic is_tab;
    logic oob;
  } char_info_t;

  // work handed to the pen sequencer
  typedef struct packed {
    logic [11:0]      bx;
    logic [11:0]      by;
    logic [11:0]      w;
    logic [11:0]      h;
    logic [11:0]      adv;
    logic [REP_W-1:0] reps;
    logic             nl;
    logic             draw;
    logic             want;
    logic             last;
  } pen_load_t;

  typedef enum logic [1:0] {
    PEN_IDLE,
    PEN_DRAW,
    PEN_BOX,
    PEN_SUM
  } pen_state_t;

endpackage

/* rtl/utlm_decode.sv */
// ----------------------------------------------------------------------------
// utlm_decode: utf-8 byte decoder
// collects lead and continuation bytes into a code point, one byte per beat
// ----------------------------------------------------------------------------
module utlm_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  text_byte,
  input  logic                        want_box,
  input  logic                        last,
  output utlm_pkg::char_info_t        info,
  output logic [utlm_pkg::CODE_W-1:0] code
);
  import utlm_pkg::*;

  logic [CODE_W-1:0] code_r, code_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic              want_r, want_nxt;

  logic [CODE_W-1:0] code_c;
  logic [1:0]        pend_c;
  logic              want_c;
  logic              done_c;

  always_comb begin
    code_c = code_r;
    pend_c = pend_r;
    want_c = want_r;
    done_c = 1'b0;
    if (pend_r == 2'd0) begin
      want_c = want_box;
      if (text_byte >= LEAD4) begin
        code_c = CODE_W'(text_byte & LEAD4_MASK);
        pend_c = 2'd3;
      end else if (text_byte >= LEAD3) begin
        code_c = CODE_W'(text_byte & LEAD3_MASK);
        pend_c = 2'd2;
      end else if (text_byte >= LEAD2) begin
        code_c = CODE_W'(text_byte & LEAD2_MASK);
        pend_c = 2'd1;
      end else begin
        code_c = CODE_W'(text_byte);
        done_c = 1'b1;
      end
    end else begin
      code_c = {code_r[CODE_W-CONT_BITS-1:0], text_byte[CONT_BITS-1:0]};
      pend_c = pend_r - 2'd1;
      done_c = (pend_r == 2'd1);
    end

    // finished code or end of run clears the sequence
    code_nxt = code_c;
    pend_nxt = pend_c;
    want_nxt = want_c;
    if (last || done_c) begin
      code_nxt = '0;
      pend_nxt = '0;
      want_nxt = 1'b0;
    end

    code        = code_c;
    info.done   = done_c;
    info.want   = want_c;
    info.last   = last;
    info.is_tab = (code_c == TAB_CODE);
    info.oob    = (32'(code_c) >= GLYPH_COUNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      pend_r <= '0;
      want_r <= 1'b0;
    end else if (step) begin
      code_r <= code_nxt;
      pend_r <= pend_nxt;
      want_r <= want_nxt;
    end
  end

endmodule

/* rtl/utlm_pen.sv */
// ----------------------------------------------------------------------------
// utlm_pen: pen sequencer and result register
// draws glyphs one per cycle, tracks bounds, emits box and run summary beats
// ----------------------------------------------------------------------------
module utlm_pen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [9:0]            line_pitch,
  input  logic                  load,
  input  utlm_pkg::pen_load_t   ld,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic signed [23:0]    out_pos_x,
  output logic signed [23:0]    out_pos_y,
  output logic signed [23:0]    out_extent_w,
  output logic signed [23:0]    out_extent_h,
  output logic [15:0]           out_line_count,
  output logic                  out_last_res
);
  import utlm_pkg::*;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'(S24_MAX)) begin
      return S24_MAX;
    end else if (v < 28'(S24_MIN)) begin
      return S24_MIN;
    end else begin
      return v[23:0];
    end
  endfunction

  pen_state_t state_r, state_base, state_nxt;

  // held character
  pen_load_t        cur_r;
  logic [REP_W-1:0] reps_r;
  logic             first_r;

  // run state
  logic signed [23:0] pen_x_r, pen_x_nxt;
  logic signed [23:0] pen_y_r, pen_y_nxt;
  logic signed [23:0] max_x_r, max_x_nxt;
  logic signed [23:0] max_y_r, max_y_nxt;
  logic signed [23:0] min_y_r, min_y_nxt;
  logic [15:0]        lines_r, lines_nxt;

  // box corners
  logic signed [23:0] x0_r, y0_r;
  logic signed [25:0] ex_r, ey_r;

  logic out_valid_r;
  logic push_ok, draw_en, push_box, push_sum;

  logic signed [25:0] bx_s, by_s, w_s, h_s, adv_s;
  logic signed [25:0] xp, yp, xa, ya, ex_c, py_dn, px_adv, ht;

  assign push_ok = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_base = state_r;
    draw_en    = 1'b0;
    push_box   = 1'b0;
    push_sum   = 1'b0;
    unique case (state_r)
      PEN_IDLE: state_base = PEN_IDLE;
      PEN_DRAW: begin
        draw_en = 1'b1;
        if (reps_r == REP_W'(1)) begin
          if (cur_r.want) begin
            state_base = PEN_BOX;
          end else if (cur_r.last) begin
            state_base = PEN_SUM;
          end else begin
            state_base = PEN_IDLE;
          end
        end
      end
      PEN_BOX: begin
        if (push_ok) begin
          push_box   = 1'b1;
          state_base = cur_r.last ? PEN_SUM : PEN_IDLE;
        end
      end
      PEN_SUM: begin
        if (push_ok) begin
          push_sum   = 1'b1;
          state_base = PEN_IDLE;
        end
      end
      default: state_base = PEN_IDLE;
    endcase
  end

  assign free = (state_base == PEN_IDLE);

  always_comb begin
    state_nxt = state_base;
    if (load) begin
      state_nxt = ld.draw ? PEN_DRAW : PEN_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PEN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one drawn glyph
  always_comb begin
    bx_s   = 26'($signed(cur_r.bx));
    by_s   = 26'($signed(cur_r.by));
    w_s    = $signed({14'd0, cur_r.w});
    h_s    = $signed({14'd0, cur_r.h});
    adv_s  = $signed({14'd0, cur_r.adv});
    xp     = 26'(pen_x_r) + bx_s;
    yp     = 26'(pen_y_r) - h_s + by_s;
    xa     = xp + adv_s;
    ya     = yp + h_s;
    ex_c   = xp + w_s;
    py_dn  = 26'(pen_y_r) - $signed({16'd0, line_pitch});
    px_adv = 26'(pen_x_r) + adv_s;
    ht     = 26'(max_y_r) - 26'(min_y_r);
  end

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    min_y_nxt = min_y_r;
    lines_nxt = lines_r;
    if (draw_en) begin
      if (xa > 26'(max_x_r)) max_x_nxt = sat24(28'(xa));
      if (ya > 26'(max_y_r)) max_y_nxt = sat24(28'(ya));
      if (yp < 26'(min_y_r)) min_y_nxt = sat24(28'(yp));
      if (cur_r.nl) begin
        pen_x_nxt = '0;
        pen_y_nxt = sat24(28'(py_dn));
        if (lines_r != LINES_MAX) lines_nxt = lines_r + 16'd1;
      end else begin
        pen_x_nxt = sat24(28'(px_adv));
      end
    end else if (push_sum) begin
      pen_x_nxt = '0;
      pen_y_nxt = '0;
      max_x_nxt = '0;
      max_y_nxt = '0;
      min_y_nxt = S24_MAX;
      lines_nxt = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      min_y_r <= S24_MAX;
      lines_r <= 16'd1;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
      min_y_r <= min_y_nxt;
      lines_r <= lines_nxt;
    end
  end

  // held character and box corners
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r   <= ld;
      reps_r  <= ld.reps;
      first_r <= 1'b1;
    end else if (draw_en) begin
      reps_r  <= reps_r - REP_W'(1);
      first_r <= 1'b0;
    end
    if (draw_en) begin
      if (first_r) begin
        x0_r <= sat24(28'(xp));
        y0_r <= sat24(28'(yp));
      end
      ex_r <= ex_c;
      ey_r <= ya;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (push_box) begin
      out_result_kind <= RES_BOX;
      out_pos_x       <= x0_r;
      out_pos_y       <= y0_r;
      out_extent_w    <= sat24(28'(ex_r) - 28'(x0_r));
      out_extent_h    <= sat24(28'(ey_r) - 28'(y0_r));
      out_line_count  <= lines_r;
      out_last_res    <= 1'b0;
    end else if (push_sum) begin
      out_result_kind <= RES_SUM;
      out_pos_x       <= pen_x_r;
      out_pos_y       <= pen_y_r;
      out_extent_w    <= max_x_r;
      out_extent_h    <= ht[25] ? '0 : sat24(28'(ht));
      out_line_count  <= lines_r;
      out_last_res    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_box || push_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/utf8_text_layout_measure_unit.sv */
// ----------------------------------------------------------------------------
// utf8_text_layout_measure_unit: utf-8 text run measure against a glyph table
// decodes text bytes, looks up glyph metrics, moves a pen and reports boxes
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake          beat carries
//   cfg_*        in    cfg_we only        line pitch in pixels
//   in_*         in    in_valid/in_ready  text byte or glyph table write
//   out_*        out   out_valid/out_ready character box or run summary
//
// - a finished character draws one glyph (TAB_SPACES for a tab), then gives
//   its box beat if asked for and a summary beat at the end of a run
// - the glyph memory read is registered and overlaps the previous character's
//   pen work: plain characters stream at one per cycle unless out_ready stalls
// - synchronous reset, no clearing pass: table entries are undefined until
//   written
// - a stalled out_ready holds the pen sequencer, then the lookup stage, then
//   in_ready
//
module utf8_text_layout_measure_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [7:0]         in_text_byte,
  input  logic               in_want_box,
  input  logic               in_last,
  input  logic [9:0]         in_glyph_index,
  input  logic signed [11:0] in_bearing_x,
  input  logic signed [11:0] in_bearing_y,
  input  logic [11:0]        in_glyph_w,
  input  logic [11:0]        in_glyph_h,
  input  logic [17:0]        in_glyph_advance,
  input  logic               in_glyph_renderable,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_result_kind,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_extent_w,
  output logic signed [23:0] out_extent_h,
  output logic [15:0]        out_line_count,
  output logic               out_last_res
);
  import utlm_pkg::*;

  logic [9:0] line_pitch_r;

  // handshake
  logic in_acc, text_acc, tbl_wr, tbl_rd;

  // decoder
  char_info_t        dec_info;
  logic [CODE_W-1:0] dec_code;

  // glyph memory, read data registered
  glyph_t              glyph_mem [GLYPH_COUNT];
  glyph_t              rdata_r;
  glyph_t              wr_glyph;
  logic [GLYPH_AW-1:0] waddr, raddr;

  // copy of the space entry, used for tabs and line breaks
  glyph_t space_r;

  // lookup stage: character waiting on its memory read
  logic       s1_valid_r;
  char_info_t s1_info_r;

  // pen sequencer hookup
  logic      pen_free, load, sel_space;
  pen_load_t ld;
  glyph_t    g_sel;

  // line pitch register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pitch_r <= LINE_PITCH_RST;
    end else if (cfg_we) begin
      line_pitch_r <= cfg_wdata;
    end
  end

  // the lookup stage frees up when its character moves to the pen
  assign load     = s1_valid_r && pen_free;
  assign in_ready = !s1_valid_r || load;
  assign in_acc   = in_valid && in_ready;
  assign text_acc = in_acc && (in_kind == KIND_TEXT);
  assign tbl_wr   = in_acc && (in_kind == KIND_GLYPH) && (32'(in_glyph_index) < GLYPH_COUNT);
  assign tbl_rd   = text_acc && dec_info.done;

  utlm_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (text_acc),
    .text_byte (in_text_byte),
    .want_box  (in_want_box),
    .last      (in_last),
    .info      (dec_info),
    .code      (dec_code)
  );

  always_comb begin
    wr_glyph.bx   = in_bearing_x;
    wr_glyph.by   = in_bearing_y;
    wr_glyph.w    = in_glyph_w;
    wr_glyph.h    = in_glyph_h;
    wr_glyph.adv  = in_glyph_advance;
    wr_glyph.rend = in_glyph_renderable;
  end

  assign waddr = GLYPH_AW'(in_glyph_index);
  assign raddr = GLYPH_AW'(dec_code);

  // reads and writes never share a cycle: one beat per cycle
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      glyph_mem[waddr] <= wr_glyph;
    end
    if (tbl_rd) begin
      rdata_r <= glyph_mem[raddr];
    end
  end

  // space shadow is read when a character leaves the lookup stage, so a
  // later write cannot reach an earlier character
  always_ff @(posedge clk) begin
    if (tbl_wr && (waddr == GLYPH_AW'(SPACE_CODE))) begin
      space_r <= wr_glyph;
    end
  end

  // only finished characters and end of run need the pen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (text_acc && (dec_info.done || dec_info.last)) begin
      s1_valid_r <= 1'b1;
    end else if (load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_info_r <= dec_info;
    end
  end

  // tab, code beyond the table or non-renderable glyph draws the space
  assign sel_space = s1_info_r.is_tab || s1_info_r.oob || !rdata_r.rend;
  assign g_sel     = sel_space ? space_r : rdata_r;

  always_comb begin
    ld.bx   = g_sel.bx;
    ld.by   = g_sel.by;
    ld.w    = g_sel.w;
    ld.h    = g_sel.h;
    ld.adv  = g_sel.adv[17:ADV_FRAC];
    ld.reps = s1_info_r.is_tab ? REP_W'(TAB_SPACES) : REP_W'(1);
    ld.nl   = !s1_info_r.is_tab && (s1_info_r.oob || !rdata_r.rend);
    ld.draw = s1_info_r.done;
    ld.want = s1_info_r.want;
    ld.last = s1_info_r.last;
  end

  utlm_pen u_pen (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_pitch      (line_pitch_r),
    .load            (load),
    .ld              (ld),
    .free            (pen_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_extent_w    (out_extent_w),
    .out_extent_h    (out_extent_h),
    .out_line_count  (out_line_count),
    .out_last_res    (out_last_res)
  );

endmodule

/* rtl/utlm_port_check.sv */
// ----------------------------------------------------------------------------
// utlm_port_check: port-level checks of the text layout measure unit
// watches the result channel over time, bound to the top level
// ----------------------------------------------------------------------------
module utlm_port_check (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic [9:0]         cfg_wdata,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic [7:0]         in_text_byte,
  input logic               in_want_box,
  input logic               in_last,
  input logic [9:0]         in_glyph_index,
  input logic signed [11:0] in_bearing_x,
  input logic signed [11:0] in_bearing_y,
  input logic [11:0]        in_glyph_w,
  input logic [11:0]        in_glyph_h,
  input logic [17:0]        in_glyph_advance,
  input logic               in_glyph_renderable,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_result_kind,
  input logic signed [23:0] out_pos_x,
  input logic signed [23:0] out_pos_y,
  input logic signed [23:0] out_extent_w,
  input logic signed [23:0] out_extent_h,
  input logic [15:0]        out_line_count,
  input logic               out_last_res
);
  import utlm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_extent_w) && $stable(out_extent_h) && $stable(out_line_count)
      && $stable(out_result_kind))
    else $error("result beat changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // run width and height of a summary are never negative
  a_sum_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RES_SUM) |-> !out_extent_w[23] && !out_extent_h[23])
    else $error("negative run extent");

  // line count starts at one and saturates, never wraps to zero
  a_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_count != 16'd0)
    else $error("line count is zero");

endmodule

bind utf8_text_layout_measure_unit utlm_port_check u_port_check (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the utf-8 text layout measure unit
// loads glyph metrics, streams utf-8 text runs under random idling on both
// sides, and checks every box and run summary beat against a predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utlm_pkg::*;

  // cycles to let the pen sequencer finish work that yields no beat
  localparam int SETTLE_CYCLES = 16;
  // mismatch lines printed before going quiet (all are still counted)
  localparam int MAX_REPORTS = 50;

  // one beat on the input channel
  typedef struct {
    logic       kind;
    logic [7:0] text_byte;
    logic       want_box;
    logic       last;
    logic [9:0] glyph_index;
    glyph_t     metrics;
  } beat_t;

  // one box or run summary as it should leave the block
  typedef struct {
    logic               kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] ext_w;
    logic signed [23:0] ext_h;
    logic [15:0]        lines;
    logic               fin;
  } measure_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [9:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KIND_TEXT;
  logic [7:0]         in_text_byte = '0;
  logic               in_want_box = 1'b0;
  logic               in_last = 1'b0;
  logic [9:0]         in_glyph_index = '0;
  logic signed [11:0] in_bearing_x = '0;
  logic signed [11:0] in_bearing_y = '0;
  logic [11:0]        in_glyph_w = '0;
  logic [11:0]        in_glyph_h = '0;
  logic [17:0]        in_glyph_advance = '0;
  logic               in_glyph_renderable = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_result_kind;
  logic signed [23:0] out_pos_x;
  logic signed [23:0] out_pos_y;
  logic signed [23:0] out_extent_w;
  logic signed [23:0] out_extent_h;
  logic [15:0]        out_line_count;
  logic               out_last_res;

  // bench bookkeeping
  bit          steady;          // no idling on either side while set
  int unsigned beats_sent;
  int unsigned err_count;
  measure_t    awaited [$];     // boxes and summaries still owed by the block

  // shadow of the block: glyph table, line pitch, decoder and pen state
  glyph_t      glyph_tab [GLYPH_COUNT];
  bit          glyph_known [GLYPH_COUNT];
  logic [9:0]  pitch_px = LINE_PITCH_RST;
  logic [20:0] code_acc;
  int unsigned seq_left;
  bit          box_flag;
  longint      pen_x, pen_y;
  longint      far_x, top_y, bottom_y;
  int unsigned line_no;

  utf8_text_layout_measure_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_text_byte        (in_text_byte),
    .in_want_box         (in_want_box),
    .in_last             (in_last),
    .in_glyph_index      (in_glyph_index),
    .in_bearing_x        (in_bearing_x),
    .in_bearing_y        (in_bearing_y),
    .in_glyph_w          (in_glyph_w),
    .in_glyph_h          (in_glyph_h),
    .in_glyph_advance    (in_glyph_advance),
    .in_glyph_renderable (in_glyph_renderable),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_pos_x           (out_pos_x),
    .out_pos_y           (out_pos_y),
    .out_extent_w        (out_extent_w),
    .out_extent_h        (out_extent_h),
    .out_line_count      (out_line_count),
    .out_last_res        (out_last_res)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // every stored or reported coordinate saturates to 24-bit signed
  function automatic longint clamp24(input longint v);
    if (v > longint'(S24_MAX)) return longint'(S24_MAX);
    if (v < longint'(S24_MIN)) return longint'(S24_MIN);
    return v;
  endfunction

  function automatic measure_t make_measure(input logic kind, input longint a,
                                            input longint b, input longint c,
                                            input longint d, input logic fin);
    measure_t m;
    m.kind  = kind;
    m.pos_x = 24'(clamp24(a));
    m.pos_y = 24'(clamp24(b));
    m.ext_w = 24'(clamp24(c));
    m.ext_h = 24'(clamp24(d));
    m.lines = 16'(line_no);
    m.fin   = fin;
    return m;
  endfunction

  // pen and bounds back to the start of a run
  function automatic void restart_run();
    code_acc = '0;
    seq_left = 0;
    box_flag = 1'b0;
    pen_x    = 0;
    pen_y    = 0;
    far_x    = 0;
    top_y    = 0;
    bottom_y = longint'(S24_MAX);
    line_no  = 1;
  endfunction

  // draw one decoded code point and move the pen
  function automatic void place_code(input logic [20:0] code, input bit want);
    logic [9:0] g;
    int         reps;
    bit         brk;
    glyph_t     gl;
    longint     bx, by, w, h, adv, xp, yp;
    longint     x0, y0, bw, bh;
    g    = code[9:0];
    reps = 1;
    brk  = 1'b0;
    x0   = 0;
    y0   = 0;
    bw   = 0;
    bh   = 0;
    if (code == TAB_CODE) begin
      // tab is a row of spaces
      g    = SPACE_CODE[9:0];
      reps = TAB_SPACES;
    end else if (code >= GLYPH_COUNT || !glyph_tab[code[9:0]].rend) begin
      // unprintable or off the table: one space, then a new line
      g   = SPACE_CODE[9:0];
      brk = 1'b1;
    end
    for (int r = 0; r < reps; r++) begin
      gl  = glyph_tab[g];
      bx  = $signed(gl.bx);
      by  = $signed(gl.by);
      w   = gl.w;
      h   = gl.h;
      adv = gl.adv >> ADV_FRAC;
      xp  = pen_x + bx;
      yp  = pen_y - (h - by);
      if (r == 0) begin
        x0 = clamp24(xp);
        y0 = clamp24(yp);
      end
      if (r == reps - 1) begin
        bw = xp + w - x0;
        bh = yp + h - y0;
      end
      if (xp + adv > far_x) far_x = clamp24(xp + adv);
      if (yp + h > top_y) top_y = clamp24(yp + h);
      if (yp < bottom_y) bottom_y = clamp24(yp);
      if (brk) begin
        pen_y = clamp24(pen_y - longint'(pitch_px));
        pen_x = 0;
        if (line_no < LINES_MAX) line_no++;
      end else begin
        pen_x = clamp24(pen_x + adv);
      end
    end
    if (want) awaited.push_back(make_measure(RES_BOX, x0, y0, bw, bh, 1'b0));
  endfunction

  // apply one accepted beat to the shadow state
  function automatic void apply_beat(input beat_t b);
    bit done;
    done = 1'b0;
    if (b.kind == KIND_GLYPH) begin
      glyph_tab[b.glyph_index]   = b.metrics;
      glyph_known[b.glyph_index] = 1'b1;
      return;
    end
    if (seq_left == 0) begin
      box_flag = b.want_box;
      if (b.text_byte >= LEAD4) begin
        code_acc = 21'(b.text_byte & LEAD4_MASK);
        seq_left = 3;
      end else if (b.text_byte >= LEAD3) begin
        code_acc = 21'(b.text_byte & LEAD3_MASK);
        seq_left = 2;
      end else if (b.text_byte >= LEAD2) begin
        code_acc = 21'(b.text_byte & LEAD2_MASK);
        seq_left = 1;
      end else begin
        // plain ascii or a stray continuation byte
        code_acc = 21'(b.text_byte);
        done     = 1'b1;
      end
    end else begin
      // continuation: low six bits, whatever the top two are
      code_acc = 21'({code_acc, b.text_byte[CONT_BITS-1:0]});
      seq_left--;
      done = (seq_left == 0);
    end
    if (done) begin
      place_code(code_acc, box_flag);
      code_acc = '0;
      box_flag = 1'b0;
    end
    if (b.last) begin
      // a half-decoded sequence is simply dropped here
      awaited.push_back(make_measure(RES_SUM, pen_x, pen_y, far_x,
                                     (top_y > bottom_y) ? top_y - bottom_y : 0, 1'b1));
      restart_run();
    end
  endfunction

  // ------------------------------------------------------------------ drivers

  // one beat on the input channel; valid holds until the handshake
  task automatic send_beat(input beat_t b);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_kind             <= b.kind;
    in_text_byte        <= b.text_byte;
    in_want_box         <= b.want_box;
    in_last             <= b.last;
    in_glyph_index      <= b.glyph_index;
    in_bearing_x        <= b.metrics.bx;
    in_bearing_y        <= b.metrics.by;
    in_glyph_w          <= b.metrics.w;
    in_glyph_h          <= b.metrics.h;
    in_glyph_advance    <= b.metrics.adv;
    in_glyph_renderable <= b.metrics.rend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_beat(b);
    beats_sent++;
  endtask

  // text beat, glyph fields carry junk the block must ignore
  task automatic send_text(input logic [7:0] tb_byte, input bit want, input bit fin);
    beat_t       b;
    logic [95:0] noise;
    noise         = {$urandom, $urandom, $urandom};
    b.kind        = KIND_TEXT;
    b.text_byte   = tb_byte;
    b.want_box    = want;
    b.last        = fin;
    b.glyph_index = 10'($urandom);
    b.metrics     = noise[$bits(glyph_t)-1:0];
    send_beat(b);
  endtask

  // glyph table write; box and last flags are junk here
  task automatic load_glyph(input logic [9:0] idx, input glyph_t m);
    beat_t b;
    b.kind        = KIND_GLYPH;
    b.text_byte   = 8'($urandom);
    b.want_box    = 1'($urandom);
    b.last        = 1'($urandom);
    b.glyph_index = idx;
    b.metrics     = m;
    send_beat(b);
  endtask

  // mostly small glyphs, a quarter of them anywhere in the field ranges
  function automatic glyph_t random_metrics();
    glyph_t      g;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    g     = noise[$bits(glyph_t)-1:0];
    if ($urandom_range(3) != 0) begin
      g.bx  = 12'($urandom_range(16)) - 12'd8;
      g.by  = 12'($urandom_range(24)) - 12'd4;
      g.w   = 12'($urandom_range(24));
      g.h   = 12'($urandom_range(24));
      g.adv = 18'($urandom_range(2047));
    end
    g.rend = ($urandom_range(9) != 0);
    return g;
  endfunction

  // one random character as utf-8; a run end may cut its sequence short
  task automatic send_char(input bit end_run);
    int unsigned pick, nbytes, keep;
    logic [20:0] code;
    logic [7:0]  seq [4];
    bit          want;
    pick   = $urandom_range(99);
    want   = 1'($urandom);
    nbytes = 1;
    if (pick < 45) begin
      code = $urandom_range(8'h7E, 8'h20);
    end else if (pick < 55) begin
      code = $urandom_range(31);
    end else if (pick < 62) begin
      code = $urandom_range(8'hBF, 8'h80);
    end else if (pick < 77) begin
      code   = $urandom_range(GLYPH_COUNT - 1, 8'h80);
      nbytes = 2;
    end else if (pick < 84) begin
      code   = $urandom_range(11'h7FF);
      nbytes = 2;
    end else if (pick < 92) begin
      // overlong encodings of table codes, or far off the table
      code   = $urandom_range(1) ? $urandom_range(GLYPH_COUNT - 1) : $urandom_range(16'hFFFF);
      nbytes = 3;
    end else begin
      code   = 21'($urandom);
      nbytes = 4;
    end
    case (nbytes)
      1: begin
        seq[0] = code[7:0];
      end
      2: begin
        seq[0] = {3'b110, code[10:6]};
      end
      3: begin
        seq[0] = {4'hE, code[15:12]};
      end
      default: begin
        seq[0] = {4'hF, 1'($urandom), code[20:18]};
      end
    endcase
    for (int i = 1; i < nbytes; i++) seq[i] = {2'($urandom), code[6*(nbytes-1-i) +: 6]};
    keep = nbytes;
    if (end_run && nbytes > 1 && $urandom_range(7) == 0) begin
      keep = $urandom_range(nbytes - 1, 1);
    end else if (code < GLYPH_COUNT && code != TAB_CODE && !glyph_known[code[9:0]]) begin
      // never look up a table entry that was not written
      load_glyph(code[9:0], random_metrics());
    end
    for (int i = 0; i < keep; i++) begin
      if (i > 0 && $urandom_range(99) < 4) load_glyph(10'($urandom), random_metrics());
      send_text(seq[i], (i == 0) ? want : 1'($urandom), end_run && (i == keep - 1));
    end
  endtask

  // runs of 1..12 characters with table rewrites mixed in
  task automatic send_runs(input int unsigned n);
    int unsigned stop_at, len;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 8) load_glyph(10'($urandom), random_metrics());
        send_char(k == len - 1);
      end
    end
  endtask

  // hold the sender until every awaited beat is back and the pen is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // line pitch only changes while the block is idle
  task automatic set_line_pitch(input logic [9:0] px);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= px;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pitch_px = px;
  endtask

  // ----------------------------------------------------------------- checking

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // receiver stalls with a chance of about 14 in 100 except in the steady stretch
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // every result beat is matched against the oldest awaited one
  always @(posedge clk) begin : result_check
    measure_t due;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        flag_error("result beat with nothing awaited");
      end else begin
        due = awaited.pop_front();
        check_field("result_kind", out_result_kind, due.kind);
        check_field("pos_x", out_pos_x, due.pos_x);
        check_field("pos_y", out_pos_y, due.pos_y);
        check_field("extent_w", out_extent_w, due.ext_w);
        check_field("extent_h", out_extent_h, due.ext_h);
        check_field("line_count", out_line_count, due.lines);
        check_field("last_res", out_last_res, due.fin);
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // space first (tabs and line breaks draw it), then field extremes
  task automatic test_glyph_table();
    load_glyph(SPACE_CODE[9:0], glyph_t'{12'd0, 12'd10, 12'd6, 12'd10, 18'd512, 1'b1});
    // 'A': most negative bearing x, largest everything else
    load_glyph(10'h041, glyph_t'{12'h800, 12'h7FF, 12'hFFF, 12'hFFF, 18'h3FFFF, 1'b1});
    // 'B': most positive bearing x, most negative bearing y, empty box
    load_glyph(10'h042, glyph_t'{12'h7FF, 12'h800, 12'h000, 12'h000, 18'h0, 1'b1});
    // newline is not drawable, so it breaks the line
    load_glyph(10'h00A, glyph_t'{12'd1, 12'd2, 12'd3, 12'd4, 18'd320, 1'b0});
    load_glyph(10'h080, glyph_t'{12'hFFE, 12'd8, 12'd7, 12'd9, 18'd448, 1'b1});
    load_glyph(10'h3FF, glyph_t'{12'd3, 12'hFFF, 12'd5, 12'd2, 18'd100, 1'b1});
  endtask

  // each utf-8 length, tab, line break, stray continuation, off-table codes
  task automatic test_utf8_forms();
    send_text(8'h41, 1'b1, 1'b0);
    send_text(8'h42, 1'b1, 1'b0);
    send_text(TAB_CODE[7:0], 1'b1, 1'b0);
    send_text(8'h0A, 1'b1, 1'b0);
    send_text(8'h80, 1'b1, 1'b0);
    // two bytes, last table entry
    send_text(8'hCF, 1'b1, 1'b0);
    send_text(8'hBF, 1'b0, 1'b0);
    // two bytes, past the table
    send_text(8'hDF, 1'b1, 1'b0);
    send_text(8'hBF, 1'b0, 1'b0);
    // overlong three bytes back onto the table, top bits of a continuation set
    send_text(8'hE0, 1'b1, 1'b0);
    send_text(8'h8F, 1'b0, 1'b0);
    send_text(8'hFF, 1'b0, 1'b0);
    // four bytes from the highest lead, closes the run
    send_text(8'hFF, 1'b1, 1'b0);
    send_text(8'hBF, 1'b1, 1'b0);
    send_text(8'hBF, 1'b0, 1'b0);
    send_text(8'hBF, 1'b0, 1'b1);
  endtask

  task automatic test_special_cases();
    // run with nothing drawn: height stays zero
    send_text(8'hF3, 1'b1, 1'b1);
    // run ends in the middle of a sequence
    send_text(8'h41, 1'b0, 1'b0);
    send_text(8'hC3, 1'b1, 1'b1);
    // box flag only on the continuation byte gives no box
    send_text(8'hCF, 1'b0, 1'b0);
    send_text(8'hBF, 1'b1, 1'b1);
  endtask

  // smallest, largest and zero pitch, a random one, then back to reset value
  task automatic test_line_pitch();
    logic [9:0] sweep [5];
    sweep = '{10'd1, 10'd1023, 10'd0, 10'($urandom_range(1023, 1)), LINE_PITCH_RST};
    foreach (sweep[i]) begin
      set_line_pitch(sweep[i]);
      send_runs(140);
    end
  endtask

  task automatic test_random_runs();
    send_runs(450);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    send_runs(250);
    steady = 1'b0;
  endtask

  // sender stops mid-run until the block has drained, then finishes the run
  task automatic test_drain_pause();
    repeat (5) begin
      repeat ($urandom_range(6, 1)) send_char(1'b0);
      wait_idle();
      send_char(1'b1);
    end
  endtask

  initial begin
    restart_run();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_glyph_table();
    test_utf8_forms();
    test_special_cases();
    test_line_pitch();
    test_random_runs();
    test_back_to_back();
    test_drain_pause();
    wait_idle();
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // hang guard, many times the slowest legal run
  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

endmodule
